// ===== rtl/posture_fall_alert_qualifier_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the posture fall alert qualifier
// Shared wrappers for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSTURE_FALL_ALERT_QUALIFIER_UNIT_ASSERT_SVH
`define POSTURE_FALL_ALERT_QUALIFIER_UNIT_ASSERT_SVH

// Same-cycle implication
`define PFAQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PFAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfaq_pkg.sv =====
// ----------------------------------------------------------------------------
// pfaq_pkg
// Types, constants and register codes of the posture fall alert qualifier.
// ----------------------------------------------------------------------------
package pfaq_pkg;

  // Field widths
  localparam int ANGLE_W    = 12;
  localparam int ACCEL_W    = 16;
  localparam int LIMIT_W    = 16;
  localparam int OUT_CNT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default counter width
  localparam int COUNT_BITS_DEF = 16;

  // Still window: 0.8 g^2 and 1.2 g^2 in Q4.12
  localparam logic [ACCEL_W-1:0] STILL_LOW_Q12  = 16'd3277;
  localparam logic [ACCEL_W-1:0] STILL_HIGH_Q12 = 16'd4915;

  // Register reset values
  localparam logic [ANGLE_W-1:0] ANGLE_THR_RST  = 12'd400;
  localparam logic [LIMIT_W-1:0] MALAISE_LIM_RST = 16'd10;
  localparam logic [LIMIT_W-1:0] IMMOB_LIM_RST   = 16'd15;
  localparam logic [LIMIT_W-1:0] FALL_LIM_RST    = 16'd20;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERT_EN     = 3'd0,
    CFG_IMMOB_EN    = 3'd1,
    CFG_FALL_EN     = 3'd2,
    CFG_ANGLE_THR   = 3'd3,
    CFG_MALAISE_LIM = 3'd4,
    CFG_IMMOB_LIM   = 3'd5,
    CFG_FALL_LIM    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic               verticality_enable;
    logic               immobility_enable;
    logic               fall_enable;
    logic [ANGLE_W-1:0] angle_threshold;
    logic [LIMIT_W-1:0] malaise_limit;
    logic [LIMIT_W-1:0] immobility_limit;
    logic [LIMIT_W-1:0] fall_limit;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] tilt_angle;
    logic [ACCEL_W-1:0] accel_sq;
    logic               fall_window;
    logic               fall_alert_active;
    logic               ack_malaise;
  } sample_t;

  typedef struct packed {
    logic                 malaise_alarm;
    logic                 fall_confirmed;
    logic [OUT_CNT_W-1:0] verticality_count;
    logic [OUT_CNT_W-1:0] still_count;
    logic [OUT_CNT_W-1:0] fall_count_out;
  } result_t;

endpackage

// ===== rtl/pfaq_stream_if.sv =====
// ----------------------------------------------------------------------------
// pfaq_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface pfaq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pfaq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pfaq_cfg_regs
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module pfaq_cfg_regs
  import pfaq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERT_EN:     cfg_nxt.verticality_enable = cfg_wdata[0];
        CFG_IMMOB_EN:    cfg_nxt.immobility_enable  = cfg_wdata[0];
        CFG_FALL_EN:     cfg_nxt.fall_enable        = cfg_wdata[0];
        CFG_ANGLE_THR:   cfg_nxt.angle_threshold    = cfg_wdata[ANGLE_W-1:0];
        CFG_MALAISE_LIM: cfg_nxt.malaise_limit      = cfg_wdata[LIMIT_W-1:0];
        CFG_IMMOB_LIM:   cfg_nxt.immobility_limit   = cfg_wdata[LIMIT_W-1:0];
        CFG_FALL_LIM:    cfg_nxt.fall_limit         = cfg_wdata[LIMIT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.verticality_enable <= 1'b1;
      cfg_r.immobility_enable  <= 1'b1;
      cfg_r.fall_enable        <= 1'b1;
      cfg_r.angle_threshold    <= ANGLE_THR_RST;
      cfg_r.malaise_limit      <= MALAISE_LIM_RST;
      cfg_r.immobility_limit   <= IMMOB_LIM_RST;
      cfg_r.fall_limit         <= FALL_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== rtl/pfaq_eval.sv =====
// ----------------------------------------------------------------------------
// pfaq_eval
// Single-pass evaluation of one sample: verticality, immobility, fall.
// ----------------------------------------------------------------------------
module pfaq_eval
  import pfaq_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  cfg_t                  cfg_i,
  input  sample_t               sample_i,
  input  logic [COUNT_BITS-1:0] low_cnt_i,
  input  logic [COUNT_BITS-1:0] still_cnt_i,
  input  logic [COUNT_BITS-1:0] fall_cnt_i,
  input  logic                  fall_conf_i,
  input  logic                  malaise_i,
  output logic [COUNT_BITS-1:0] low_cnt_o,
  output logic [COUNT_BITS-1:0] still_cnt_o,
  output logic [COUNT_BITS-1:0] fall_cnt_o,
  output logic                  fall_conf_o,
  output logic                  malaise_o,
  output result_t               result_o
);

  // Common width for count/limit compares and output trimming
  localparam int CW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  low;
  logic                  still;
  logic                  mf_ack;
  logic                  mf_vert;
  logic                  mf_immob;
  logic                  blocked;
  logic [COUNT_BITS-1:0] low_inc;
  logic [COUNT_BITS-1:0] still_inc;
  logic [COUNT_BITS-1:0] fall_inc;
  logic [CW-1:0]         low_wide;
  logic [CW-1:0]         still_wide;
  logic [CW-1:0]         fall_wide;

  // Sample qualifiers
  assign low   = sample_i.tilt_angle < cfg_i.angle_threshold;
  assign still = (sample_i.accel_sq >= STILL_LOW_Q12) &&
                 (sample_i.accel_sq <= STILL_HIGH_Q12);

  // Saturating increments
  assign low_inc   = (low_cnt_i == CNT_MAX) ? CNT_MAX : low_cnt_i + 1'b1;
  assign still_inc = (still_cnt_i == CNT_MAX) ? CNT_MAX : still_cnt_i + 1'b1;
  assign fall_inc  = (fall_cnt_i == CNT_MAX) ? CNT_MAX : fall_cnt_i + 1'b1;

  assign low_wide   = CW'(low_inc);
  assign still_wide = CW'(still_inc);
  assign fall_wide  = CW'(fall_inc);

  assign mf_ack  = malaise_i & ~sample_i.ack_malaise;
  assign blocked = fall_conf_i | sample_i.fall_alert_active;

  // Loss of verticality, then immobility, then fall: each sees the flags before it
  always_comb begin
    low_cnt_o   = low_cnt_i;
    still_cnt_o = still_cnt_i;
    fall_cnt_o  = fall_cnt_i;
    fall_conf_o = fall_conf_i;
    mf_vert     = mf_ack;
    mf_immob    = mf_ack;

    if (cfg_i.verticality_enable) begin
      if (low && !mf_ack && !blocked) begin
        if (low_wide >= CW'(cfg_i.malaise_limit)) begin
          mf_vert   = 1'b1;
          low_cnt_o = '0;
        end else begin
          low_cnt_o = low_inc;
        end
      end else begin
        low_cnt_o = '0;
      end
    end

    mf_immob = mf_vert;
    if (cfg_i.immobility_enable) begin
      if (still && !mf_vert && !blocked) begin
        if (still_wide >= CW'(cfg_i.immobility_limit)) begin
          mf_immob    = 1'b1;
          still_cnt_o = '0;
        end else begin
          still_cnt_o = still_inc;
        end
      end else begin
        still_cnt_o = '0;
      end
    end

    if (cfg_i.fall_enable) begin
      if (low && sample_i.fall_window && !mf_immob && !sample_i.fall_alert_active) begin
        fall_cnt_o = fall_inc;
        if (fall_wide >= CW'(cfg_i.fall_limit)) begin
          fall_conf_o = 1'b1;
        end
      end else begin
        fall_conf_o = 1'b0;
        fall_cnt_o  = '0;
      end
    end
  end

  assign malaise_o = mf_immob;

  // Result item: flags and counters trimmed to the output width
  always_comb begin
    logic [CW-1:0] lw;
    logic [CW-1:0] sw;
    logic [CW-1:0] fw;
    lw = CW'(low_cnt_o);
    sw = CW'(still_cnt_o);
    fw = CW'(fall_cnt_o);
    result_o.malaise_alarm     = mf_immob;
    result_o.fall_confirmed    = fall_conf_o;
    result_o.verticality_count = lw[OUT_CNT_W-1:0];
    result_o.still_count       = sw[OUT_CNT_W-1:0];
    result_o.fall_count_out    = fw[OUT_CNT_W-1:0];
  end

endmodule

// ===== rtl/posture_fall_alert_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// posture_fall_alert_qualifier_unit
// Qualifies malaise and fall alarms from one posture sample per transfer.
// ----------------------------------------------------------------------------
// The unit takes one sample per clock while in_ch.ready is high and returns
// one result per sample: the sample lands in an input register, and the
// evaluation and the alarm state update happen as it moves on into the result
// register. Throughput is one item per cycle while the output accepts results,
// set by the combinational update of the three counters and two flags; the
// result register decouples the sides, so a stalled output only blocks input
// once both registers hold items. Configuration writes are taken at any cycle
// and should only be issued while no sample is in flight.
`include "posture_fall_alert_qualifier_unit_assert.svh"

module posture_fall_alert_qualifier_unit
  import pfaq_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pfaq_stream_if.sink           in_ch,
  pfaq_stream_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg;
  sample_t               sample_r;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  result_t               result_r;
  result_t               result_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_adv;
  logic                  s1_adv;
  logic                  in_xfer;

  logic [COUNT_BITS-1:0] low_cnt_r;
  logic [COUNT_BITS-1:0] low_cnt_nxt;
  logic [COUNT_BITS-1:0] still_cnt_r;
  logic [COUNT_BITS-1:0] still_cnt_nxt;
  logic [COUNT_BITS-1:0] fall_cnt_r;
  logic [COUNT_BITS-1:0] fall_cnt_nxt;
  logic                  fall_conf_r;
  logic                  fall_conf_nxt;
  logic                  malaise_r;
  logic                  malaise_nxt;

  pfaq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Handshake: result register frees on transfer, input stage follows
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  pfaq_eval #(
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .cfg_i       (cfg),
    .sample_i    (sample_r),
    .low_cnt_i   (low_cnt_r),
    .still_cnt_i (still_cnt_r),
    .fall_cnt_i  (fall_cnt_r),
    .fall_conf_i (fall_conf_r),
    .malaise_i   (malaise_r),
    .low_cnt_o   (low_cnt_nxt),
    .still_cnt_o (still_cnt_nxt),
    .fall_cnt_o  (fall_cnt_nxt),
    .fall_conf_o (fall_conf_nxt),
    .malaise_o   (malaise_nxt),
    .result_o    (result_nxt)
  );

  // Control and alarm state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      low_cnt_r   <= '0;
      still_cnt_r <= '0;
      fall_cnt_r  <= '0;
      fall_conf_r <= 1'b0;
      malaise_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        low_cnt_r   <= low_cnt_nxt;
        still_cnt_r <= still_cnt_nxt;
        fall_cnt_r  <= fall_cnt_nxt;
        fall_conf_r <= fall_conf_nxt;
        malaise_r   <= malaise_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_ch.data;
    end
    if (s1_adv) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = result_r;

  // Malaise and fall confirmation exclude each other
  `PFAQ_ASSERT_NOW(a_flags_exclusive, 1'b1, !(malaise_r && fall_conf_r), "malaise and fall both set")
  // An advancing item always fills the result register
  `PFAQ_ASSERT_NEXT(a_result_loaded, s1_adv, out_valid_r, "result register not loaded")
  // Alarm state moves only with an evaluated item
  `PFAQ_ASSERT_NEXT(a_state_hold, !s1_adv, $stable(malaise_r) && $stable(fall_conf_r) && $stable(fall_cnt_r), "state changed without item")

endmodule
